// ===== src/wbit_pkg.sv =====
package wbit_pkg;

    localparam int PAGES  = 3;
    localparam int PAGE_W = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int FMT_STAGES = 5;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MINUTES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORK_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_HALF_MS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_TOTAL   = 3'd5;

    localparam logic [15:0] RST_HOLD_MS      = 16'd1000;
    localparam logic [7:0]  RST_MAX_MINUTES  = 8'd180;
    localparam logic [7:0]  RST_WORK_STEP    = 8'd10;
    localparam logic [7:0]  RST_BREAK_STEP   = 8'd5;
    localparam logic [15:0] RST_BEEP_HALF_MS = 16'd500;
    localparam logic [3:0]  RST_BEEP_TOTAL   = 4'd3;

    localparam logic [2:0] MODE_SET_WORK  = 3'd0;
    localparam logic [2:0] MODE_SET_BREAK = 3'd1;
    localparam logic [2:0] MODE_WORK_RUN  = 3'd2;
    localparam logic [2:0] MODE_BREAK_RUN = 3'd3;
    localparam logic [2:0] MODE_ALERT     = 3'd4;

    localparam logic [23:0] MS_PER_MIN  = 24'd60000;
    localparam logic [13:0] SEC_PER_MIN = 14'd60;
    // floor(x / 1000) = (x * RECIP_1000) >> 34 for x < 2^24
    localparam logic [24:0] RECIP_1000  = 25'd17179870;
    // floor(x / 60) = (x * RECIP_60) >> 24 for x < 2^14
    localparam logic [18:0] RECIP_60    = 19'd279621;

    typedef enum logic [4:0] {
        PH_SET_WORK  = 5'b00001,
        PH_SET_BREAK = 5'b00010,
        PH_WORK_RUN  = 5'b00100,
        PH_BREAK_RUN = 5'b01000,
        PH_ALERT     = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [15:0] hold_ms;
        logic [7:0]  max_minutes;
        logic [7:0]  work_step;
        logic [7:0]  break_step;
        logic [15:0] beep_half_ms;
        logic [3:0]  beep_total;
    } t_cfg;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        t_phase            phase;
        logic              buzzer;
        logic [7:0]        work_minutes;
        logic [7:0]        rest_minutes;
    } t_info;

    typedef struct packed {
        t_info       info;
        logic [7:0]  run_len;
        logic [31:0] diff_ms;
    } t_snap;

    function automatic logic [7:0] set_step(input logic [7:0] len, input logic [7:0] step,
                                            input logic [7:0] max_len);
        logic [8:0] sum;
        sum = {1'b0, len} + {1'b0, step};
        return (sum > {1'b0, max_len}) ? 8'd0 : sum[7:0];
    endfunction

endpackage

// ===== src/wbit_if.sv =====
interface wbit_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        select_button;
    logic        page_button;

    modport source (output valid, output now_ms, output select_button, output page_button,
                    input ready);
    modport sink   (input valid, input now_ms, input select_button, input page_button,
                    output ready);
endinterface

interface wbit_out_if;
    logic                       valid;
    logic                       ready;
    logic [wbit_pkg::PAGE_W-1:0] page;
    logic [2:0]                 mode;
    logic                       buzzer;
    logic [7:0]                 work_minutes;
    logic [7:0]                 rest_minutes;
    logic [7:0]                 left_minutes;
    logic [5:0]                 left_seconds;

    modport source (output valid, output page, output mode, output buzzer,
                    output work_minutes, output rest_minutes, output left_minutes,
                    output left_seconds, input ready);
    modport sink   (input valid, input page, input mode, input buzzer,
                    input work_minutes, input rest_minutes, input left_minutes,
                    input left_seconds, output ready);
endinterface

interface wbit_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wbit_pkg::CFG_IDX_W-1:0]  index;
    logic [wbit_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/wbit_cfg.sv =====
module wbit_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    wbit_cfg_if.sink       i_cfg,
    output wbit_pkg::t_cfg o_cfg
);

    wbit_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ms      <= wbit_pkg::RST_HOLD_MS;
            r_cfg.max_minutes  <= wbit_pkg::RST_MAX_MINUTES;
            r_cfg.work_step    <= wbit_pkg::RST_WORK_STEP;
            r_cfg.break_step   <= wbit_pkg::RST_BREAK_STEP;
            r_cfg.beep_half_ms <= wbit_pkg::RST_BEEP_HALF_MS;
            r_cfg.beep_total   <= wbit_pkg::RST_BEEP_TOTAL;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                wbit_pkg::REG_HOLD_MS:      r_cfg.hold_ms      <= i_cfg.data;
                wbit_pkg::REG_MAX_MINUTES:  r_cfg.max_minutes  <= i_cfg.data[7:0];
                wbit_pkg::REG_WORK_STEP:    r_cfg.work_step    <= i_cfg.data[7:0];
                wbit_pkg::REG_BREAK_STEP:   r_cfg.break_step   <= i_cfg.data[7:0];
                wbit_pkg::REG_BEEP_HALF_MS: r_cfg.beep_half_ms <= i_cfg.data;
                wbit_pkg::REG_BEEP_TOTAL:   r_cfg.beep_total   <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== src/wbit_ctrl.sv =====
module wbit_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  wbit_pkg::t_cfg  i_cfg,
    input  logic [31:0]     i_now_ms,
    input  logic            i_select_button,
    input  logic            i_page_button,
    output wbit_pkg::t_snap o_snap
);

    logic [wbit_pkg::PAGE_W-1:0] r_page, n_page;
    wbit_pkg::t_phase            r_phase, n_phase;
    logic [7:0]                  r_work, n_work;
    logic [7:0]                  r_rest, n_rest;
    logic [31:0]                 r_phase_start, n_phase_start;
    logic [31:0]                 r_press_start, n_press_start;
    logic [31:0]                 r_beep_start, n_beep_start;
    logic                        r_prev_sel, r_prev_page;
    logic [3:0]                  r_beep_count, n_beep_count;
    logic                        r_buzz, n_buzz;
    logic                        r_alert_begun, n_alert_begun;

    logic        rise, fall;
    logic [31:0] press_dur;
    logic [31:0] phase_dur;
    logic [7:0]  cur_len;
    logic [23:0] run_lim;

    assign rise      = i_select_button & ~r_prev_sel;
    assign fall      = ~i_select_button & r_prev_sel;
    assign press_dur = i_now_ms - r_press_start;
    assign phase_dur = i_now_ms - r_phase_start;
    assign cur_len   = (r_phase == wbit_pkg::PH_WORK_RUN) ? r_work : r_rest;
    assign run_lim   = {16'd0, cur_len} * wbit_pkg::MS_PER_MIN;

    always_comb begin
        n_page        = r_page;
        n_phase       = r_phase;
        n_work        = r_work;
        n_rest        = r_rest;
        n_phase_start = r_phase_start;
        n_press_start = r_press_start;
        n_beep_start  = r_beep_start;
        n_beep_count  = r_beep_count;
        n_buzz        = r_buzz;
        n_alert_begun = r_alert_begun;

        if (i_page_button && !r_prev_page) begin
            n_page = (r_page == wbit_pkg::PAGE_W'(wbit_pkg::PAGES - 1)) ? '0 : r_page + 1'b1;
        end

        if (n_page == '0) begin
            unique case (r_phase)
                wbit_pkg::PH_SET_WORK, wbit_pkg::PH_SET_BREAK: begin
                    if (rise) begin
                        n_press_start = i_now_ms;
                    end
                    if (fall) begin
                        if (press_dur <= {16'd0, i_cfg.hold_ms}) begin
                            if (r_phase == wbit_pkg::PH_SET_WORK) begin
                                n_work = wbit_pkg::set_step(r_work, i_cfg.work_step,
                                                            i_cfg.max_minutes);
                            end else begin
                                n_rest = wbit_pkg::set_step(r_rest, i_cfg.break_step,
                                                            i_cfg.max_minutes);
                            end
                        end else begin
                            n_phase_start = i_now_ms;
                            n_phase = (r_phase == wbit_pkg::PH_SET_WORK) ?
                                      wbit_pkg::PH_SET_BREAK : wbit_pkg::PH_WORK_RUN;
                        end
                    end
                end
                wbit_pkg::PH_WORK_RUN, wbit_pkg::PH_BREAK_RUN: begin
                    if (phase_dur >= {8'd0, run_lim}) begin
                        if (r_phase == wbit_pkg::PH_WORK_RUN) begin
                            n_work        = '0;
                            n_phase_start = i_now_ms;
                            n_phase       = wbit_pkg::PH_BREAK_RUN;
                        end else begin
                            n_rest        = '0;
                            n_phase_start = '0;
                            n_phase       = wbit_pkg::PH_ALERT;
                        end
                    end
                    if (rise) begin
                        n_press_start = i_now_ms;
                    end
                    if (fall && press_dur >= {16'd0, i_cfg.hold_ms}) begin
                        n_alert_begun = 1'b0;
                        n_work        = '0;
                        n_rest        = '0;
                        n_phase       = wbit_pkg::PH_SET_WORK;
                    end
                end
                wbit_pkg::PH_ALERT: begin
                    if (!r_alert_begun) begin
                        n_alert_begun = 1'b1;
                        n_beep_start  = i_now_ms;
                        n_beep_count  = '0;
                        n_buzz        = 1'b1;
                    end
                    if ((i_now_ms - n_beep_start) >= {16'd0, i_cfg.beep_half_ms}) begin
                        n_beep_start = i_now_ms;
                        if (n_buzz) begin
                            n_buzz       = 1'b0;
                            n_beep_count = n_beep_count + 1'b1;
                        end else begin
                            n_buzz = 1'b1;
                        end
                    end
                    if (n_beep_count >= i_cfg.beep_total) begin
                        n_buzz        = 1'b0;
                        n_beep_count  = '0;
                        n_alert_begun = 1'b0;
                        n_phase       = wbit_pkg::PH_SET_WORK;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_snap.info.page         = n_page;
        o_snap.info.phase        = n_phase;
        o_snap.info.buzzer       = n_buzz;
        o_snap.info.work_minutes = n_work;
        o_snap.info.rest_minutes = n_rest;
        o_snap.diff_ms           = i_now_ms - n_phase_start;
        priority case (1'b1)
            n_phase == wbit_pkg::PH_WORK_RUN:  o_snap.run_len = n_work;
            n_phase == wbit_pkg::PH_BREAK_RUN: o_snap.run_len = n_rest;
            default:                           o_snap.run_len = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page        <= '0;
            r_phase       <= wbit_pkg::PH_SET_WORK;
            r_work        <= '0;
            r_rest        <= '0;
            r_phase_start <= '0;
            r_press_start <= '0;
            r_beep_start  <= '0;
            r_prev_sel    <= 1'b0;
            r_prev_page   <= 1'b0;
            r_beep_count  <= '0;
            r_buzz        <= 1'b0;
            r_alert_begun <= 1'b0;
        end else if (i_take) begin
            r_page        <= n_page;
            r_phase       <= n_phase;
            r_work        <= n_work;
            r_rest        <= n_rest;
            r_phase_start <= n_phase_start;
            r_press_start <= n_press_start;
            r_beep_start  <= n_beep_start;
            r_prev_sel    <= i_select_button;
            r_prev_page   <= i_page_button;
            r_beep_count  <= n_beep_count;
            r_buzz        <= n_buzz;
            r_alert_begun <= n_alert_begun;
        end
    end

`ifndef ASSERT_OFF
    a_buzz_only_in_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buzz |-> r_phase == wbit_pkg::PH_ALERT)
        else $error("buzzer on outside alert");

    a_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |=> r_page <= wbit_pkg::PAGE_W'(wbit_pkg::PAGES - 1))
        else $error("page counter out of range");

    a_frozen_off_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && n_page != '0) |=> $stable(r_phase) && $stable(r_work) && $stable(r_rest))
        else $error("timer moved on another page");
`endif

endmodule

// ===== src/wbit_fmt.sv =====
module wbit_fmt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  wbit_pkg::t_snap i_snap,
    output logic            o_adv,
    wbit_out_if.source      o_out
);

    logic [wbit_pkg::FMT_STAGES-1:0] r_v;
    logic [wbit_pkg::FMT_STAGES-1:0] en;

    wbit_pkg::t_snap r_s0;

    wbit_pkg::t_info r_i1;
    logic            r_exp1;
    logic [13:0]     r_total1;
    logic [23:0]     r_d1;
    logic [7:0]      r_len1;

    wbit_pkg::t_info r_i2;
    logic            r_exp2;
    logic [13:0]     r_total2;
    logic [14:0]     r_el2;

    wbit_pkg::t_info r_i3;
    logic [13:0]     r_rem3;
    logic [7:0]      r_q3;

    wbit_pkg::t_info r_i4;
    logic [7:0]      r_lm4;
    logic [5:0]      r_ls4;

    logic [23:0] lim0;
    logic [48:0] prod_el;
    logic [13:0] rem2;
    logic [32:0] prod_q;
    logic [13:0] q_times_60;
    logic        run3;

    assign en[wbit_pkg::FMT_STAGES-1] = ~r_v[wbit_pkg::FMT_STAGES-1] | o_out.ready;
    for (genvar k = 0; k < wbit_pkg::FMT_STAGES - 1; k++) begin : g_en
        assign en[k] = ~r_v[k] | en[k+1];
    end
    assign o_adv = en[0];

    assign lim0       = {16'd0, r_s0.run_len} * wbit_pkg::MS_PER_MIN;
    assign prod_el    = 49'(r_d1) * 49'(wbit_pkg::RECIP_1000);
    assign rem2       = r_exp2 ? 14'd0 : r_total2 - r_el2[13:0];
    assign prod_q     = 33'(rem2) * 33'(wbit_pkg::RECIP_60);
    assign q_times_60 = 14'(r_q3) * wbit_pkg::SEC_PER_MIN;
    assign run3       = (r_i3.phase == wbit_pkg::PH_WORK_RUN) ||
                        (r_i3.phase == wbit_pkg::PH_BREAK_RUN);

    function automatic logic [2:0] mode_code(input wbit_pkg::t_phase ph);
        unique case (ph)
            wbit_pkg::PH_SET_WORK:  return wbit_pkg::MODE_SET_WORK;
            wbit_pkg::PH_SET_BREAK: return wbit_pkg::MODE_SET_BREAK;
            wbit_pkg::PH_WORK_RUN:  return wbit_pkg::MODE_WORK_RUN;
            wbit_pkg::PH_BREAK_RUN: return wbit_pkg::MODE_BREAK_RUN;
            wbit_pkg::PH_ALERT:     return wbit_pkg::MODE_ALERT;
            default:                return wbit_pkg::MODE_SET_WORK;
        endcase
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_take;
            for (int k = 1; k < wbit_pkg::FMT_STAGES; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0 <= i_snap;
        end
        if (en[1]) begin
            r_i1     <= r_s0.info;
            r_exp1   <= r_s0.diff_ms >= {8'd0, lim0};
            r_total1 <= 14'(r_s0.run_len) * wbit_pkg::SEC_PER_MIN;
            r_d1     <= r_s0.diff_ms[23:0];
            r_len1   <= r_s0.run_len;
        end
        if (en[2]) begin
            r_i2     <= r_i1;
            r_exp2   <= r_exp1 | (r_len1 == 8'd0);
            r_total2 <= r_total1;
            r_el2    <= prod_el[48:34];
        end
        if (en[3]) begin
            r_i3   <= r_i2;
            r_rem3 <= rem2;
            r_q3   <= prod_q[31:24];
        end
        if (en[4]) begin
            r_i4 <= r_i3;
            priority case (1'b1)
                r_i3.phase == wbit_pkg::PH_SET_WORK:  r_lm4 <= r_i3.work_minutes;
                r_i3.phase == wbit_pkg::PH_SET_BREAK: r_lm4 <= r_i3.rest_minutes;
                run3:                                 r_lm4 <= r_q3;
                default:                              r_lm4 <= '0;
            endcase
            r_ls4 <= run3 ? 6'(r_rem3 - q_times_60) : 6'd0;
        end
    end

    assign o_out.valid        = r_v[wbit_pkg::FMT_STAGES-1];
    assign o_out.page         = r_i4.page;
    assign o_out.mode         = mode_code(r_i4.phase);
    assign o_out.buzzer       = r_i4.buzzer;
    assign o_out.work_minutes = r_i4.work_minutes;
    assign o_out.rest_minutes = r_i4.rest_minutes;
    assign o_out.left_minutes = r_lm4;
    assign o_out.left_seconds = r_ls4;

`ifndef ASSERT_OFF
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.left_seconds < 6'd60)
        else $error("seconds out of range");

    a_sec_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.mode != wbit_pkg::MODE_WORK_RUN &&
         o_out.mode != wbit_pkg::MODE_BREAK_RUN) |-> o_out.left_seconds == 6'd0)
        else $error("seconds shown outside a run");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[wbit_pkg::FMT_STAGES-1] && !o_out.ready && r_v[wbit_pkg::FMT_STAGES-2])
        |=> r_v[wbit_pkg::FMT_STAGES-2])
        else $error("stage dropped a beat under stall");
`endif

endmodule

// ===== src/work_break_interval_timer_top.sv =====
// Channel   Role   Beat contents
// i_in      sink   now_ms, select_button, page_button
// o_out     source page, mode, buzzer, work_minutes, rest_minutes, left_minutes, left_seconds
// i_cfg     sink   index, data (register write, always ready)
//
// One poll per clock while i_in.ready is high. The timer state updates at the edge that
// takes the poll; the time readout runs through a five-register formatting pipeline (divide
// by 1000 and by 60 as reciprocal multiplies); o_out.valid rises as the last stage fills.
// A stage holds only while it and every stage after it are full and o_out.ready is
// low, so i_in.ready drops once all five are full and o_out.ready is low.
// Synchronous active-low reset clears timer state, valid bits and restores register
// defaults; no clearing pass.
module work_break_interval_timer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wbit_in_if.sink    i_in,
    wbit_out_if.source o_out,
    wbit_cfg_if.sink   i_cfg
);

    wbit_pkg::t_cfg  cfg;
    wbit_pkg::t_snap snap;
    logic            adv;
    logic            take;

    assign take       = i_in.valid & adv;
    assign i_in.ready = adv;

    wbit_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    wbit_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_cfg           (cfg),
        .i_now_ms        (i_in.now_ms),
        .i_select_button (i_in.select_button),
        .i_page_button   (i_in.page_button),
        .o_snap          (snap)
    );

    wbit_fmt u_fmt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_snap  (snap),
        .o_adv   (adv),
        .o_out   (o_out)
    );

endmodule
